@@ hw/rtl/mlps_pkg.sv @@
// Shared constants and types for the Mobius and least-prime sieve engine.
`default_nettype none

package mlps_pkg;

    // Field widths fixed by the request and result formats.
    localparam int REQ_W   = 2;
    localparam int NUM_W   = 13;
    localparam int STAT_W  = 2;
    localparam int MU_W    = 2;
    localparam int CNT_W   = 10;
    localparam int LIMIT_W = 13;

    // Sizes of the stores; the field widths above are chosen to hold them.
    localparam int MAX_LIMIT  = 4096;
    localparam int MAX_PRIMES = 564;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [MU_W-1:0]   mu_code_t;

    // Request codes.
    localparam req_t REQ_BUILD  = 2'd0;
    localparam req_t REQ_NUMBER = 2'd1;
    localparam req_t REQ_INDEX  = 2'd2;

    // Status codes.
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_RANGE   = 2'd1;
    localparam status_t ST_UNBUILT = 2'd2;

    // Mobius codes as kept in the store; the code bits read directly as a signed value.
    localparam mu_code_t MU_ZERO = 2'd0;
    localparam mu_code_t MU_POS  = 2'd1;
    localparam mu_code_t MU_NEG  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

endpackage

`default_nettype wire

@@ hw/rtl/mobius_least_prime_sieve_unit.sv @@
// Top level of the sieve engine: sequencer, stores and query path.
//
// Usage: a request is taken on a clock edge where start is high and busy is low;
// req_type and number are sampled there. Each request produces exactly one result,
// shown for one cycle with done high; the receiver cannot stall it.
// A number query or an index query makes one registered read of the stores, then
// loads the result register; busy stays high until then, so requests do not overlap.
// Error answers (unknown request, bad limit, out of range, not built) take the same path.
// A build request sieves 1..sieve_limit with one shared adder stepping through the store.
// The build time is set by the single read/write port pair of the sign/factor store.
// sieve_limit is written through cfg_valid/cfg_ready while the block is idle;
// cfg_ready is low while busy.
// Reset clears the built mark, so queries answer not built until the first build;
// sieve_limit resets to 4096. The stores need no clearing at reset.
`default_nettype none

module mobius_least_prime_sieve_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [mlps_pkg::REQ_W-1:0]          req_type,
    input  wire logic [mlps_pkg::NUM_W-1:0]          number,
    output logic                                     done,
    output logic      [mlps_pkg::STAT_W-1:0]         status,
    output logic signed [mlps_pkg::MU_W-1:0]         mobius,
    output logic      [mlps_pkg::NUM_W-1:0]          least_prime,
    output logic                                     is_prime,
    output logic      [mlps_pkg::CNT_W-1:0]          prime_total,
    output logic      [mlps_pkg::NUM_W-1:0]          prime_value,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mlps_pkg::LIMIT_W-1:0]        sieve_limit
);

    localparam int NUM_W   = mlps_pkg::NUM_W;
    localparam int CNT_W   = mlps_pkg::CNT_W;
    localparam int LIMIT_W = mlps_pkg::LIMIT_W;

    localparam int AW = $clog2(mlps_pkg::MAX_LIMIT + 1);
    localparam int SW = AW + 1;
    localparam int EW = AW + 2;
    localparam int PW = $clog2(mlps_pkg::MAX_PRIMES + 1);
    localparam int QW = 2 * AW;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_Q_RD    = 5'd1;
    localparam logic [4:0] S_CLR     = 5'd2;
    localparam logic [4:0] S_P1_RD   = 5'd3;
    localparam logic [4:0] S_P1_CHK  = 5'd4;
    localparam logic [4:0] S_SV_RD   = 5'd5;
    localparam logic [4:0] S_SV_WR   = 5'd6;
    localparam logic [4:0] S_P1_NEXT = 5'd7;
    localparam logic [4:0] S_P2_INIT = 5'd8;
    localparam logic [4:0] S_P2_RD   = 5'd9;
    localparam logic [4:0] S_P2_WR   = 5'd10;
    localparam logic [4:0] S_P3_RD   = 5'd11;
    localparam logic [4:0] S_P3_CHK  = 5'd12;
    localparam logic [4:0] S_P3_SQ   = 5'd13;
    localparam logic [4:0] S_ZR_WR   = 5'd14;
    localparam logic [4:0] S_P3_NEXT = 5'd15;
    localparam logic [4:0] S_FIN     = 5'd16;

    logic [4:0]                 state_reg, state_next;
    logic [AW-1:0]              j_reg, j_next;
    logic [AW-1:0]              walk_reg, walk_next;
    logic [AW-1:0]              step_reg, step_next;
    logic [QW-1:0]              sq_reg, sq_next;
    logic [AW-1:0]              lim_reg, lim_next;
    logic [AW-1:0]              built_reg, built_next;
    logic [PW-1:0]              found_reg, found_next;
    logic [PW-1:0]              listed_reg, listed_next;
    logic [CNT_W-1:0]           pc_reg, pc_next;
    logic [LIMIT_W-1:0]         cfg_limit_reg;
    mlps_pkg::status_t          q_status_reg, q_status_next;
    logic                       q_index_reg, q_index_next;
    logic [AW-1:0]              q_num_reg, q_num_next;

    logic                       done_reg, done_next;
    mlps_pkg::status_t          status_reg, status_next;
    logic [1:0]                 mobius_reg, mobius_next;
    logic [NUM_W-1:0]           lp_out_reg, lp_out_next;
    logic                       isp_reg, isp_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [NUM_W-1:0]           pval_reg, pval_next;

    // Store ports.
    logic                       st_we;
    logic [AW-1:0]              st_waddr, st_raddr;
    logic [EW-1:0]              st_wdata, st_rdata;
    logic                       cn_we;
    logic [AW-1:0]              cn_waddr;
    logic [CNT_W-1:0]           cn_wdata, cn_rdata;
    logic                       pl_we;
    logic [PW-1:0]              pl_waddr;
    logic [AW-1:0]              pl_wdata, pl_rdata;

    // Shared adder.
    logic                       alu_use_j, alu_one;
    logic [SW-1:0]              alu_a, alu_b, alu_sum;
    logic                       alu_over;

    logic [AW-1:0]              e_lp;
    mlps_pkg::mu_code_t         e_code;
    logic                       cfg_ok;
    logic                       p2_prime;
    logic [CNT_W-1:0]           p2_count;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;

    assign e_lp   = st_rdata[EW-1:2];
    assign e_code = st_rdata[1:0];

    assign cfg_ok = (cfg_limit_reg >= LIMIT_W'(2)) &&
                    (32'(cfg_limit_reg) <= mlps_pkg::MAX_LIMIT);

    assign p2_prime = (e_lp == j_reg);
    assign p2_count = pc_reg + CNT_W'(p2_prime);

    assign alu_use_j = (state_reg == S_P1_NEXT) || (state_reg == S_P2_WR) ||
                       (state_reg == S_P3_NEXT);
    assign alu_one   = alu_use_j || (state_reg == S_CLR);
    assign alu_a     = alu_use_j ? SW'(j_reg) : SW'(walk_reg);
    assign alu_b     = alu_one ? SW'(1) : SW'(step_reg);

    mlps_alu #(
        .W(SW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .bound (SW'(lim_reg)),
        .sum   (alu_sum),
        .over  (alu_over)
    );

    mlps_ram #(
        .WIDTH(EW),
        .DEPTH(mlps_pkg::MAX_LIMIT + 1)
    ) u_sign_factor_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mlps_ram #(
        .WIDTH(CNT_W),
        .DEPTH(mlps_pkg::MAX_LIMIT + 1)
    ) u_count_ram (
        .clk   (clk),
        .we    (cn_we),
        .waddr (cn_waddr),
        .wdata (cn_wdata),
        .raddr (AW'(number)),
        .rdata (cn_rdata)
    );

    mlps_ram #(
        .WIDTH(AW),
        .DEPTH(mlps_pkg::MAX_PRIMES + 1)
    ) u_prime_list_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (PW'(number)),
        .rdata (pl_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        j_next        = j_reg;
        walk_next     = walk_reg;
        step_next     = step_reg;
        sq_next       = sq_reg;
        lim_next      = lim_reg;
        built_next    = built_reg;
        found_next    = found_reg;
        listed_next   = listed_reg;
        pc_next       = pc_reg;
        q_status_next = q_status_reg;
        q_index_next  = q_index_reg;
        q_num_next    = q_num_reg;

        done_next     = 1'b0;
        status_next   = status_reg;
        mobius_next   = mobius_reg;
        lp_out_next   = lp_out_reg;
        isp_next      = isp_reg;
        count_next    = count_reg;
        pval_next     = pval_reg;

        st_we    = 1'b0;
        st_waddr = walk_reg;
        st_wdata = '0;
        st_raddr = walk_reg;
        cn_we    = 1'b0;
        cn_waddr = j_reg;
        cn_wdata = p2_count;
        pl_we    = 1'b0;
        pl_waddr = listed_reg + PW'(1);
        pl_wdata = j_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                st_raddr = AW'(number);
                if (start)
                begin
                    q_num_next   = AW'(number);
                    q_index_next = (req_type == mlps_pkg::REQ_INDEX);
                    state_next   = S_Q_RD;
                    priority if (req_type == mlps_pkg::REQ_BUILD)
                    begin
                        if (cfg_ok)
                        begin
                            lim_next   = AW'(cfg_limit_reg);
                            walk_next  = AW'(2);
                            state_next = S_CLR;
                        end
                        else
                        begin
                            q_status_next = mlps_pkg::ST_RANGE;
                        end
                    end
                    else if (req_type == mlps_pkg::REQ_NUMBER)
                    begin
                        if (built_reg == '0)
                            q_status_next = mlps_pkg::ST_UNBUILT;
                        else if (number == '0 || 32'(number) > 32'(built_reg))
                            q_status_next = mlps_pkg::ST_RANGE;
                        else
                            q_status_next = mlps_pkg::ST_OK;
                    end
                    else if (req_type == mlps_pkg::REQ_INDEX)
                    begin
                        if (built_reg == '0)
                            q_status_next = mlps_pkg::ST_UNBUILT;
                        else if (32'(number) > 32'(found_reg))
                            q_status_next = mlps_pkg::ST_RANGE;
                        else
                            q_status_next = mlps_pkg::ST_OK;
                    end
                    else
                    begin
                        q_status_next = mlps_pkg::ST_RANGE;
                    end
                end
            end

            S_Q_RD:
            begin
                done_next   = 1'b1;
                status_next = q_status_reg;
                mobius_next = '0;
                lp_out_next = '0;
                isp_next    = 1'b0;
                count_next  = '0;
                pval_next   = '0;
                if (q_status_reg == mlps_pkg::ST_OK)
                begin
                    if (q_index_reg)
                    begin
                        pval_next = NUM_W'(pl_rdata);
                    end
                    else
                    begin
                        mobius_next = e_code;
                        lp_out_next = (e_code == mlps_pkg::MU_ZERO) ? '0 : NUM_W'(e_lp);
                        isp_next    = (e_code == mlps_pkg::MU_NEG) && (e_lp == q_num_reg);
                        count_next  = cn_rdata;
                    end
                end
                state_next = S_IDLE;
            end

            // Clear entries 2..L; entry 1 is written later and entry 0 is never used.
            S_CLR:
            begin
                st_we    = 1'b1;
                st_waddr = walk_reg;
                st_wdata = '0;
                if (alu_over)
                begin
                    j_next     = AW'(2);
                    state_next = S_P1_RD;
                end
                else
                begin
                    walk_next = alu_sum[AW-1:0];
                end
            end

            S_P1_RD:
            begin
                st_raddr   = j_reg;
                state_next = S_P1_CHK;
            end

            // An entry with no factor yet is a prime: walk its multiples.
            S_P1_CHK:
            begin
                if (e_lp == '0)
                begin
                    walk_next  = j_reg;
                    step_next  = j_reg;
                    state_next = S_SV_RD;
                end
                else
                begin
                    state_next = S_P1_NEXT;
                end
            end

            S_SV_RD:
            begin
                st_raddr   = walk_reg;
                state_next = S_SV_WR;
            end

            // Keep the first factor found and flip the parity of distinct factors.
            S_SV_WR:
            begin
                st_we    = 1'b1;
                st_waddr = walk_reg;
                st_wdata = {((e_lp != '0) ? e_lp : j_reg), 1'b0, ~e_code[0]};
                if (alu_over)
                begin
                    state_next = S_P1_NEXT;
                end
                else
                begin
                    walk_next  = alu_sum[AW-1:0];
                    state_next = S_SV_RD;
                end
            end

            S_P1_NEXT:
            begin
                if (alu_over)
                begin
                    state_next = S_P2_INIT;
                end
                else
                begin
                    j_next     = alu_sum[AW-1:0];
                    state_next = S_P1_RD;
                end
            end

            S_P2_INIT:
            begin
                st_we       = 1'b1;
                st_waddr    = AW'(1);
                st_wdata    = {{AW{1'b0}}, mlps_pkg::MU_POS};
                cn_we       = 1'b1;
                cn_waddr    = AW'(1);
                cn_wdata    = '0;
                pl_we       = 1'b1;
                pl_waddr    = '0;
                pl_wdata    = AW'(1);
                pc_next     = '0;
                listed_next = '0;
                j_next      = AW'(2);
                state_next  = S_P2_RD;
            end

            S_P2_RD:
            begin
                st_raddr   = j_reg;
                state_next = S_P2_WR;
            end

            S_P2_WR:
            begin
                st_we    = 1'b1;
                st_waddr = j_reg;
                st_wdata = {e_lp, (e_code[0] ? mlps_pkg::MU_NEG : mlps_pkg::MU_POS)};
                cn_we    = 1'b1;
                cn_waddr = j_reg;
                cn_wdata = p2_count;
                pc_next  = p2_count;
                if (p2_prime && (32'(listed_reg) < mlps_pkg::MAX_PRIMES))
                begin
                    pl_we       = 1'b1;
                    listed_next = listed_reg + PW'(1);
                end
                if (alu_over)
                begin
                    j_next     = AW'(2);
                    state_next = S_P3_RD;
                end
                else
                begin
                    j_next     = alu_sum[AW-1:0];
                    state_next = S_P2_RD;
                end
            end

            S_P3_RD:
            begin
                st_raddr   = j_reg;
                state_next = S_P3_CHK;
            end

            S_P3_CHK:
            begin
                if ((e_lp == j_reg) && (e_code == mlps_pkg::MU_NEG))
                begin
                    sq_next    = QW'(j_reg) * QW'(j_reg);
                    state_next = S_P3_SQ;
                end
                else
                begin
                    state_next = S_P3_NEXT;
                end
            end

            // Squares only grow with the prime, so the first one past the limit ends the pass.
            S_P3_SQ:
            begin
                if (sq_reg > QW'(lim_reg))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    walk_next  = sq_reg[AW-1:0];
                    step_next  = sq_reg[AW-1:0];
                    state_next = S_ZR_WR;
                end
            end

            S_ZR_WR:
            begin
                st_we    = 1'b1;
                st_waddr = walk_reg;
                st_wdata = '0;
                if (alu_over)
                begin
                    state_next = S_P3_NEXT;
                end
                else
                begin
                    walk_next = alu_sum[AW-1:0];
                end
            end

            S_P3_NEXT:
            begin
                if (alu_over)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    j_next     = alu_sum[AW-1:0];
                    state_next = S_P3_RD;
                end
            end

            S_FIN:
            begin
                built_next  = lim_reg;
                found_next  = listed_reg;
                done_next   = 1'b1;
                status_next = mlps_pkg::ST_OK;
                mobius_next = '0;
                lp_out_next = '0;
                isp_next    = 1'b0;
                count_next  = CNT_W'(listed_reg);
                pval_next   = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            built_reg     <= '0;
            found_reg     <= '0;
            cfg_limit_reg <= mlps_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            built_reg <= built_next;
            found_reg <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_limit_reg <= sieve_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        walk_reg     <= walk_next;
        step_reg     <= step_next;
        sq_reg       <= sq_next;
        lim_reg      <= lim_next;
        listed_reg   <= listed_next;
        pc_reg       <= pc_next;
        q_status_reg <= q_status_next;
        q_index_reg  <= q_index_next;
        q_num_reg    <= q_num_next;
        status_reg   <= status_next;
        mobius_reg   <= mobius_next;
        lp_out_reg   <= lp_out_next;
        isp_reg      <= isp_next;
        count_reg    <= count_next;
        pval_reg     <= pval_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign mobius      = $signed(mobius_reg);
    assign least_prime = lp_out_reg;
    assign is_prime    = isp_reg;
    assign prime_total = count_reg;
    assign prime_value = pval_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mlps_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mlps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [ADDR_W-1:0]             waddr,
    input  wire logic [WIDTH-1:0]              wdata,
    input  wire logic [ADDR_W-1:0]             raddr,
    output logic      [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mlps_alu.sv @@
// Shared adder and bound compare used for every index step of the build sequencer.
`default_nettype none

module mlps_alu #(
    parameter int W = 14
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] bound,
    output logic      [W-1:0] sum,
    output logic              over
);

    // Operands stay below half the range, so the sum never wraps.
    assign sum  = a + b;
    assign over = (sum > bound);

endmodule

`default_nettype wire
